// ----- rtl/core/lfd_pkg.sv -----
// Package for the length-prefixed frame deframer.
// Parse phase type, register indexes and frame constants; no dependencies.
`default_nettype none

package lfd_pkg;

	// Parse phases of the deframer
	typedef enum logic [2:0] {
		PH_HUNT,
		PH_SEQ,
		PH_LEN,
		PH_BODY,
		PH_TAIL,
		PH_EMIT
	} phase_t;

	// Configuration register indexes
	localparam logic [1:0] REG_HEAD    = 2'd0;
	localparam logic [1:0] REG_TAIL    = 2'd1;
	localparam logic [1:0] REG_MAX_LEN = 2'd2;

	// Register reset values
	localparam logic [7:0] HEAD_RESET    = 8'd170;
	localparam logic [7:0] TAIL_RESET    = 8'd85;
	localparam logic [5:0] MAX_LEN_RESET = 6'd57;

	// Head, sequence, length, two CRC bytes and tail
	localparam int FRAME_OVERHEAD  = 6;
	// Largest frame ever emitted
	localparam int MAX_FRAME_BYTES = 64;
	// Byte count of a frame: 0 .. MAX_FRAME_BYTES
	localparam int FILL_W          = 7;

endpackage

`default_nettype wire

// ----- rtl/core/lfd_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; the read register only updates when a read is enabled.
`default_nettype none

module lfd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port, holds its value between reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/length_prefixed_frame_deframer.sv -----
// Length-prefixed frame deframer: top level.
// Depends on lfd_pkg and lfd_ram (frame store).
//
// Usage:
//  Input channel (in_valid / in_stall / rx_byte_in) takes one received byte
//  per transfer. The block hunts for head_byte, then takes sequence, length L,
//  L command/data bytes, two CRC bytes and the tail. L must be 1..max_data_len+1
//  and the frame must fit the store, otherwise the block hunts again.
//  Output channel (out_valid / out_stall / frame_byte, byte_index,
//  last_of_frame) delivers a good frame, head first, tail last, one byte per
//  transfer. A wrong tail discards the frame silently.
//  Throughput: one received byte per cycle while a frame arrives. After a good
//  tail the frame is read back out of the single-port-read store, one byte per
//  cycle while the receiver does not stall, and the input is stalled until the
//  last read has been issued. After the tail transfer the block enters the emit
//  phase, then reads the head byte into the store's read register, which is the
//  output register.
//  When the receiver stalls, the pending byte holds and readout pauses.
//  Reset: registers return to head 170, tail 85, max length 57; the block hunts.
//  The store is not cleared; only bytes of the current frame are read. The user
//  writes configuration (cfg_we/cfg_index/cfg_data) only while idle; unenforced.
`default_nettype none

module length_prefixed_frame_deframer #(
	parameter int FRAME_STORE_DEPTH = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// configuration
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [7:0] cfg_data,
	// received bytes
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] rx_byte_in,
	// frame bytes
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      frame_byte,
	output logic [5:0]      byte_index,
	output logic            last_of_frame
);

	import lfd_pkg::*;

	localparam int ADDR_W   = $clog2(FRAME_STORE_DEPTH);
	// Largest frame that both the store and the output index allow
	localparam int MAX_FILL = (FRAME_STORE_DEPTH < MAX_FRAME_BYTES) ?
		FRAME_STORE_DEPTH : MAX_FRAME_BYTES;
	localparam logic [8:0] MAX_FILL_W = 9'(MAX_FILL);

	// Configuration registers
	logic [7:0] head_q;
	logic [7:0] tail_q;
	logic [5:0] max_len_q;

	// Parser state
	phase_t            phase_q, phase_d;
	logic [FILL_W-1:0] fill_q, fill_d;
	logic [7:0]        len_q;
	logic [5:0]        emit_idx_q;

	// Output side
	logic       out_valid_q;
	logic [5:0] idx_q;
	logic       last_q;

	// Combinational control
	logic              in_xfer;
	logic              out_free;
	logic              rd_issue;
	logic              emit_last;
	logic              head_hit;
	logic              tail_hit;
	logic              len_ok;
	logic              body_done;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [7:0]        rd_data;

	assign in_xfer  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign head_hit = rx_byte_in == head_q;
	assign tail_hit = rx_byte_in == tail_q;

	// Length check: non-zero, within max_data_len + 1, frame fits the store
	assign len_ok = (rx_byte_in != 8'd0)
		&& ({1'b0, rx_byte_in} <= ({3'b000, max_len_q} + 9'd1))
		&& (({1'b0, rx_byte_in} + 9'(FRAME_OVERHEAD)) <= MAX_FILL_W);

	// Body ends once the byte at L + 4 (second CRC byte) is written
	assign body_done = {2'b00, fill_q} >= ({1'b0, len_q} + 9'(FRAME_OVERHEAD - 2));

	// Readout: in the emit phase a read goes out whenever the output register is free
	assign rd_issue  = (phase_q == PH_EMIT) && out_free;
	assign emit_last = {1'b0, emit_idx_q} == (fill_q - 7'd1);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= HEAD_RESET;
			tail_q    <= TAIL_RESET;
			max_len_q <= MAX_LEN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEAD:    head_q    <= cfg_data;
				REG_TAIL:    tail_q    <= cfg_data;
				REG_MAX_LEN: max_len_q <= cfg_data[5:0];
				default:     ;
			endcase
		end
	end

	// Next parse phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_HUNT: if (in_xfer && head_hit) phase_d = PH_SEQ;
			PH_SEQ:  if (in_xfer) phase_d = PH_LEN;
			PH_LEN:  if (in_xfer) phase_d = len_ok ? PH_BODY : PH_HUNT;
			PH_BODY: if (in_xfer && body_done) phase_d = PH_TAIL;
			PH_TAIL: if (in_xfer) phase_d = tail_hit ? PH_EMIT : PH_HUNT;
			PH_EMIT: if (rd_issue && emit_last) phase_d = PH_HUNT;
			default: phase_d = PH_HUNT;
		endcase
	end

	// Store writes and fill count
	always_comb begin
		wr_en    = 1'b0;
		wr_addr  = ADDR_W'(fill_q);
		fill_d   = fill_q;
		in_stall = 1'b0;
		case (phase_q)
			PH_HUNT: begin
				wr_addr = '0;
				if (in_xfer && head_hit) begin
					wr_en  = 1'b1;
					fill_d = 7'd1;
				end
			end
			PH_SEQ, PH_BODY: begin
				if (in_xfer) begin
					wr_en  = 1'b1;
					fill_d = fill_q + 7'd1;
				end
			end
			PH_LEN: begin
				if (in_xfer) begin
					wr_en  = len_ok;
					fill_d = len_ok ? fill_q + 7'd1 : 7'd0;
				end
			end
			PH_TAIL: begin
				if (in_xfer) begin
					wr_en  = tail_hit;
					fill_d = tail_hit ? fill_q + 7'd1 : 7'd0;
				end
			end
			PH_EMIT: begin
				in_stall = 1'b1;
			end
			default: ;
		endcase
	end

	// Parser registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			fill_q     <= '0;
			len_q      <= '0;
			emit_idx_q <= '0;
		end else begin
			phase_q <= phase_d;
			fill_q  <= fill_d;
			if (phase_q == PH_LEN && in_xfer && len_ok) begin
				len_q <= rx_byte_in;
			end
			if (phase_q == PH_TAIL) begin
				emit_idx_q <= '0;
			end else if (rd_issue) begin
				emit_idx_q <= emit_idx_q + 6'd1;
			end
		end
	end

	// Output register control; the data byte sits in the store's read register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rd_issue) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_issue) begin
			idx_q  <= emit_idx_q;
			last_q <= emit_last;
		end
	end

	// Frame store
	lfd_ram #(
		.WIDTH (8),
		.DEPTH (FRAME_STORE_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (rx_byte_in),
		.rd_en   (rd_issue),
		.rd_addr (ADDR_W'(emit_idx_q)),
		.rd_data (rd_data)
	);

	assign out_valid     = out_valid_q;
	assign frame_byte    = rd_data;
	assign byte_index    = idx_q;
	assign last_of_frame = last_q;

	// Readout only starts after a good tail transfer
	a_emit_after_tail: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(in_stall) |-> $past(phase_q == PH_TAIL && in_xfer && tail_hit))
		else $error("readout started without a matching tail");

	// A frame is streamed without gaps once a byte is taken
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_frame |=> out_valid)
		else $error("gap inside an emitted frame");

	// Byte index counts up by one inside a frame
	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_frame |=> byte_index == $past(byte_index) + 6'd1)
		else $error("byte index did not advance by one");

	// Fill count never exceeds the largest frame
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{2'b00, fill_q} <= MAX_FILL_W)
		else $error("fill count beyond frame limit");

endmodule

`default_nettype wire
